// File: design/nbbr_pkg.sv
`timescale 1ns / 1ps

package nbbr_pkg;

    // Opcodes of an input transaction
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NO_REPL  = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLOCK_SHIFT   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_COUNT   = 2'd1;
    localparam logic [1:0] CFG_RESERVE_LIMIT = 2'd2;
    localparam logic [1:0] CFG_TABLE_ENABLED = 2'd3;

    // Configuration reset values
    localparam logic [4:0]  BLOCK_SHIFT_RESET   = 5'd17;
    localparam logic [15:0] BLOCK_COUNT_RESET   = 16'd2048;
    localparam logic [6:0]  RESERVE_LIMIT_RESET = 7'd40;

    // Blocks kept for the table itself and for factory data
    localparam int RESERVED_TABLE_BLOCKS   = 3;
    localparam int RESERVED_FACTORY_BLOCKS = 5;

    localparam logic [15:0] NO_REPLACEMENT = 16'hFFFF;

    // Classes of work handed from front to back
    localparam logic [2:0] KIND_PASS    = 3'd0;
    localparam logic [2:0] KIND_SCAN    = 3'd1;
    localparam logic [2:0] KIND_INSERT  = 3'd2;
    localparam logic [2:0] KIND_NO_REPL = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;
    localparam logic [2:0] KIND_NOP     = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] flash_address;
        logic [15:0] source_block;
        logic [15:0] target_block;
    } cmd_t;

    typedef struct packed {
        logic [31:0] mapped_address;
        logic        was_remapped;
        logic [1:0]  status;
        logic [7:0]  entries_used;
    } result_t;

    typedef struct packed {
        logic [4:0]  block_shift;
        logic [15:0] block_count;
        logic [6:0]  reserve_limit;
        logic        table_enabled;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] flash_address;
        logic [15:0] block;
        logic [15:0] source_block;
        logic [15:0] target_block;
    } item_t;

endpackage

// File: design/nbbr_front.sv
`timescale 1ns / 1ps

module nbbr_front
    import nbbr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  start,
    input  cmd_t  cmd,
    output logic  busy,
    input  logic  queue_full,
    output logic  push,
    output item_t item
);

    localparam int RESERVED_BLOCKS = RESERVED_TABLE_BLOCKS + RESERVED_FACTORY_BLOCKS;

    logic        stage_valid_reg;
    logic        stage_valid_next;
    item_t       stage_item_reg;
    item_t       classified;
    logic        accept;
    logic [31:0] block_full;
    logic [17:0] area_limit;
    logic        in_area;

    // Split the address and test it against the mapped area
    always_comb
    begin
        block_full = cmd.flash_address >> cfg.block_shift;
        area_limit = 18'(cfg.block_count) - 18'(RESERVED_BLOCKS) - 18'(cfg.reserve_limit);
        in_area    = !area_limit[17] && (block_full[31:16] == 16'd0) &&
                     (block_full != 32'd0) && ({2'b00, block_full[15:0]} < area_limit);
    end

    // Classify the incoming transaction
    always_comb
    begin
        classified.flash_address = cmd.flash_address;
        classified.block         = block_full[15:0];
        classified.source_block  = cmd.source_block;
        classified.target_block  = cmd.target_block;
        case (cmd.opcode)
            OP_LOOKUP:
            begin
                classified.kind = (in_area && cfg.table_enabled) ? KIND_SCAN : KIND_PASS;
            end
            OP_INSERT:
            begin
                classified.kind = (cmd.target_block == NO_REPLACEMENT) ? KIND_NO_REPL
                                                                        : KIND_INSERT;
            end
            OP_CLEAR:
            begin
                classified.kind = KIND_CLEAR;
            end
            default:
            begin
                classified.kind = KIND_NOP;
            end
        endcase
    end

    // Hold one classified transaction until the queue takes it
    assign busy   = stage_valid_reg && queue_full;
    assign accept = start && !busy;
    assign push   = stage_valid_reg && !queue_full;
    assign item   = stage_item_reg;

    assign stage_valid_next = accept || (stage_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= classified;
        end
    end

endmodule

// File: design/nbbr_fifo.sv
`timescale 1ns / 1ps

module nbbr_fifo
    import nbbr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t pop_item
);

    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    item_t      slot_reg [2];

    assign full     = (fill_reg == 2'd2);
    assign valid    = (fill_reg != 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/nbbr_back.sv
`timescale 1ns / 1ps

module nbbr_back
    import nbbr_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int MAX_HOPS    = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    pop,
    output logic    done,
    output result_t result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HW = $clog2(MAX_HOPS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          pend_reg;
    logic          pend_next;
    logic [HW-1:0] hops_reg;
    logic [HW-1:0] hops_next;
    logic [15:0]   cur_reg;
    logic [15:0]   cur_next;
    logic [31:0]   addr_reg;
    logic [15:0]   block_reg;
    logic          load_item;
    logic          done_reg;
    logic          done_next;
    result_t       result_reg;
    result_t       result_next;

    logic [31:0]   mem [TABLE_DEPTH];
    logic [31:0]   rdata_reg;
    logic          rd_en;
    logic          mem_we;
    logic          table_full;
    logic          hit;
    logic [31:0]   rebuilt;

    assign done   = done_reg;
    assign result = result_reg;

    assign table_full = (16'(count_reg) >= 16'(cfg.reserve_limit)) ||
                        (16'(count_reg) >= 16'(TABLE_DEPTH));
    assign hit        = pend_reg && (rdata_reg[31:16] == cur_reg);
    assign rebuilt    = (32'(cur_reg) << cfg.block_shift) |
                        (addr_reg & ~(32'hFFFF_FFFF << cfg.block_shift));

    // Sequence transactions and the entry-by-entry table scan
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        hops_next   = hops_reg;
        cur_next    = cur_reg;
        load_item   = 1'b0;
        done_next   = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        mem_we      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    pop         = 1'b1;
                    done_next   = 1'b1;
                    result_next = '{32'd0, 1'b0, STATUS_OK, 8'(count_reg)};
                    case (item.kind)
                        KIND_PASS:
                        begin
                            result_next.mapped_address = item.flash_address;
                        end
                        KIND_SCAN:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.mapped_address = item.flash_address;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                load_item  = 1'b1;
                                cur_next   = item.block;
                                hops_next  = '0;
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (table_full)
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                result_next.entries_used = 8'(count_next);
                            end
                        end
                        KIND_NO_REPL:
                        begin
                            result_next.status = STATUS_NO_REPL;
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            result_next.entries_used = 8'd0;
                        end
                        default:
                        begin
                            result_next.status = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue the next read while comparing the previous one
                rd_en     = (idx_reg < count_reg);
                pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                result_next = '{addr_reg, 1'b0, STATUS_OK, 8'(count_reg)};
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (hops_reg == HW'(MAX_HOPS))
                    begin
                        result_next.status = STATUS_TOO_LONG;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Follow the chain: rescan from the first entry
                        cur_next  = rdata_reg[15:0];
                        hops_next = hops_reg + 1'b1;
                        idx_next  = '0;
                    end
                end
                else if (!pend_reg && !rd_en)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (cur_reg != block_reg)
                    begin
                        result_next.mapped_address = rebuilt;
                        result_next.was_remapped   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            hops_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            hops_reg  <= hops_next;
            done_reg  <= done_next;
        end
    end

    // Hold lookup context and result payload
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        result_reg <= result_next;
        if (load_item)
        begin
            addr_reg  <= item.flash_address;
            block_reg <= item.block;
        end
    end

    // Relocation table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= {item.source_block, item.target_block};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end
    end

endmodule

// File: design/nand_bad_block_remap_table_core.sv
`timescale 1ns / 1ps

// NAND bad-block relocation table with address translation.
// Command channel: drive cmd and raise start; the transaction is taken on a
// clock edge where start is high and busy is low. Opcodes: lookup, insert,
// clear (any other code returns a zero address with status OK).
// Result channel: done pulses for one cycle with result valid; every command
// gives exactly one result, in command order. The receiver cannot stall.
// Configuration: cfg_write with cfg_index/cfg_data writes block_shift,
// block_count, reserve_limit, table_enabled; write only while idle.
// Structure: a front stage classifies the command, a two-entry queue decouples
// it from the back end. Insert, clear and pass-through lookups pass through
// the front stage register, the queue and the back end's result register. A
// lookup that searches the table scans it one entry per cycle from one RAM
// read port, with hops limited to MAX_HOPS + 1 scans.
// Commands keep being accepted until the queue and front stage fill.
// Reset: table empty, configuration at its defaults, table disabled. Table
// RAM contents are not cleared; only entries below the fill count are read.

module nand_bad_block_remap_table_core
    import nbbr_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int MAX_HOPS    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  queue_full;
    logic  push;
    item_t front_item;
    logic  queue_valid;
    logic  pop;
    item_t queue_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_shift   <= BLOCK_SHIFT_RESET;
            cfg_reg.block_count   <= BLOCK_COUNT_RESET;
            cfg_reg.reserve_limit <= RESERVE_LIMIT_RESET;
            cfg_reg.table_enabled <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BLOCK_SHIFT:   cfg_reg.block_shift   <= cfg_data[4:0];
                CFG_BLOCK_COUNT:   cfg_reg.block_count   <= cfg_data;
                CFG_RESERVE_LIMIT: cfg_reg.reserve_limit <= cfg_data[6:0];
                CFG_TABLE_ENABLED: cfg_reg.table_enabled <= cfg_data[0];
                default:           cfg_reg.table_enabled <= cfg_reg.table_enabled;
            endcase
        end
    end

    nbbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    nbbr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (pop),
        .valid     (queue_valid),
        .pop_item  (queue_item)
    );

    nbbr_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_HOPS    (MAX_HOPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item       (queue_item),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

endmodule
